// ----- sv/rgb_to_hsl_fixed_defines.svh -----
// Assertion macros for the RGB to HSL converter, used by its top level.
`ifndef RGB_TO_HSL_FIXED_DEFINES_SVH
`define RGB_TO_HSL_FIXED_DEFINES_SVH

// Check that cons holds in the same cycle as ante; uses the clock and reset of the host module.
`define RGBHSL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define RGBHSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rgbhsl_pkg.sv -----
// Types and constants of the RGB to HSL converter.
package rgbhsl_pkg;

   localparam int COMP_W      = 8;             // one color component
   localparam int SUM_W       = COMP_W + 1;    // max + min
   localparam int DEN_W       = SUM_W;         // divisor of both dividers
   localparam int QUO_W       = 16;            // fractional quotient bits
   localparam int DIV_STAGES  = 4;             // register stages of a divider
   localparam int DIV_STEP    = QUO_W / DIV_STAGES;
   localparam int STAGE_CNT   = DIV_STAGES + 3; // front, divider, hue combine, scale
   localparam int HUE_W       = 15;
   localparam int SAT_W       = 16;
   localparam int LIGHT_W     = 16;
   localparam int LIGHT_SHIFT = LIGHT_W - SUM_W;
   localparam int ANGLE_W     = 19;            // hue in 65536 per sextant
   localparam int ANGLE_EXT_W = ANGLE_W + 1;   // signed working width
   localparam int HUE_SCALE   = 15;
   localparam int HUE_SHIFT   = 8;
   localparam int HUE_PROD_W  = HUE_W + HUE_SHIFT;
   localparam int HUE_CIRCLE  = 23040;

   localparam logic [ANGLE_W-1:0] OFS_GREEN   = 19'h20000;
   localparam logic [ANGLE_W-1:0] OFS_BLUE    = 19'h40000;
   localparam logic [ANGLE_W-1:0] FULL_CIRCLE = 19'h60000;
   localparam logic [QUO_W:0]     HUE_UNIT    = 17'h10000;
   localparam logic [SAT_W-1:0]   SAT_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      SEXT_RED,
      SEXT_GREEN,
      SEXT_BLUE
   } sextant_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]   hue;
      logic [SAT_W-1:0]   saturation;
      logic [LIGHT_W-1:0] lightness;
   } hsl_type;

   // Per-pixel lightness and flags that ride alongside the dividers.
   typedef struct packed {
      logic [LIGHT_W-1:0] light;
      logic               gray;
      logic               sat_full;
      logic               hue_full;
      logic               hue_neg;
      sextant_type        sext;
   } side_type;

endpackage

// ----- sv/rgbhsl_if.sv -----
// Valid/ready channel interfaces for pixels in and HSL results out.
interface rgbhsl_req_if;
   logic                  valid;
   logic                  ready;
   rgbhsl_pkg::pixel_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rgbhsl_rsp_if;
   logic                valid;
   logic                ready;
   rgbhsl_pkg::hsl_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rgb_to_hsl_fixed.sv -----
// Top level of the RGB to HSL converter: one 8-bit RGB pixel in, one fixed-point HSL result out.
// Input channel req_if carries red, green and blue; output channel rsp_if carries hue
// (1/64 degree, 0..23039), saturation (65536 is one, clamped to 65535) and lightness
// ((max + min) * 128). Every accepted pixel gives exactly one result, in order.
// From the accepting edge to rsp_if.valid a pixel passes through seven register
// stages: one front stage (max, min, sum, divisor, sextant), loaded at the accepting edge,
// four divider stages, one hue combine stage and one scale stage that is also the output
// register. The depth follows from the two 16-bit fractional divisions, which retire four
// quotient bits per stage.
// Throughput is one pixel per clock while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_if.ready drops; nothing is lost or repeated, and it resumes the cycle ready returns.
// While the output register is empty the pipeline keeps advancing, so bubbles drain.
// Reset is synchronous and active high; it clears the valid bits of all stages and holds
// req_if.ready low, so no beat is taken while reset is high.
// The block holds no configuration and no state between pixels.
`include "rgb_to_hsl_fixed_defines.svh"

module rgb_to_hsl_fixed (
   input  logic                clock,
   input  logic                reset,
   rgbhsl_req_if.sink          req_if,
   rgbhsl_rsp_if.source        rsp_if
);

   localparam int CW   = rgbhsl_pkg::COMP_W;
   localparam int SW   = rgbhsl_pkg::SUM_W;
   localparam int DW   = rgbhsl_pkg::DEN_W;
   localparam int QW   = rgbhsl_pkg::QUO_W;
   localparam int NSTG = rgbhsl_pkg::STAGE_CNT;
   localparam int NDIV = rgbhsl_pkg::DIV_STAGES;
   localparam int AW   = rgbhsl_pkg::ANGLE_W;
   localparam int AXW  = rgbhsl_pkg::ANGLE_EXT_W;
   localparam int PW   = rgbhsl_pkg::HUE_PROD_W;

   // one global advance: the pipeline moves whenever the output register can drain
   logic adv;
   logic [NSTG-1:0] valid_ff;

   assign adv          = !valid_ff[NSTG-1] || rsp_if.ready;
   assign req_if.ready = adv && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NSTG-2:0], req_if.valid};
      end
   end

   // ---------------- front stage: extremes, divisors, sextant ----------------
   logic [CW-1:0]           mx, mn, chroma, hue_mag;
   logic [SW-1:0]           sum;
   logic [DW-1:0]           sat_den;
   logic [SW-1:0]           diff;
   rgbhsl_pkg::side_type    side_in;
   rgbhsl_pkg::pixel_type   px;

   always_comb begin
      px = req_if.data;
      mx = px.red;
      mn = px.red;
      if (px.green > mx) mx = px.green;
      if (px.blue  > mx) mx = px.blue;
      if (px.green < mn) mn = px.green;
      if (px.blue  < mn) mn = px.blue;
      sum    = {1'b0, mx} + {1'b0, mn};
      chroma = mx - mn;
      // dark half divides by the sum, light half by 512 minus the sum
      sat_den = sum[SW-1] ? (DW'(0) - DW'(sum)) : DW'(sum);

      // first component equal to max picks the sextant
      if (px.red == mx) begin
         side_in.sext = rgbhsl_pkg::SEXT_RED;
      end else if (px.green == mx) begin
         side_in.sext = rgbhsl_pkg::SEXT_GREEN;
      end else begin
         side_in.sext = rgbhsl_pkg::SEXT_BLUE;
      end

      case (side_in.sext)
         rgbhsl_pkg::SEXT_RED:   diff = {1'b0, px.green} - {1'b0, px.blue};
         rgbhsl_pkg::SEXT_GREEN: diff = {1'b0, px.blue}  - {1'b0, px.red};
         rgbhsl_pkg::SEXT_BLUE:  diff = {1'b0, px.red}   - {1'b0, px.green};
         default:                diff = '0;
      endcase

      // divide the magnitude, so the quotient truncates toward zero
      side_in.hue_neg  = diff[SW-1];
      hue_mag          = CW'(diff[SW-1] ? (SW'(0) - diff) : diff);
      side_in.hue_full = (hue_mag == chroma);
      side_in.sat_full = (mn == '0);   // chroma equals the divisor only when min is zero
      side_in.gray     = (mx == mn);
      side_in.light    = {sum, rgbhsl_pkg::LIGHT_SHIFT'(0)};
   end

   rgbhsl_pkg::side_type side_ff [NDIV+1];
   logic [CW-1:0] sat_num_ff, hue_num_ff;
   logic [DW-1:0] sat_den_ff, hue_den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= NDIV; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         sat_num_ff <= chroma;
         sat_den_ff <= sat_den;
         hue_num_ff <= hue_mag;
         hue_den_ff <= DW'(chroma);
      end
   end

   // ---------------- divider stages ----------------
   logic [QW-1:0] sat_quo, hue_quo;

   rgbhsl_div u_sat_div (
      .clock (clock),
      .adv   (adv),
      .num   (sat_num_ff),
      .den   (sat_den_ff),
      .quo   (sat_quo)
   );

   rgbhsl_div u_hue_div (
      .clock (clock),
      .adv   (adv),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quo   (hue_quo)
   );

   // ---------------- hue combine: sign, sextant offset, wrap ----------------
   rgbhsl_pkg::side_type sd;
   logic [QW:0]          hue_q;
   logic [AW-1:0]        hue_ofs;
   logic [AXW-1:0]       hue_sum;
   logic [AW-1:0]        hue_wrap_in, hue_wrap_ff;
   logic [rgbhsl_pkg::SAT_W-1:0]   sat_in, sat_ff;
   logic [rgbhsl_pkg::LIGHT_W-1:0] light_ff;

   always_comb begin
      sd    = side_ff[NDIV];
      hue_q = sd.hue_full ? rgbhsl_pkg::HUE_UNIT : {1'b0, hue_quo};
      case (sd.sext)
         rgbhsl_pkg::SEXT_RED:   hue_ofs = '0;
         rgbhsl_pkg::SEXT_GREEN: hue_ofs = rgbhsl_pkg::OFS_GREEN;
         rgbhsl_pkg::SEXT_BLUE:  hue_ofs = rgbhsl_pkg::OFS_BLUE;
         default:                hue_ofs = '0;
      endcase
      hue_sum = sd.hue_neg ? ({1'b0, hue_ofs} - AXW'(hue_q))
                           : ({1'b0, hue_ofs} + AXW'(hue_q));
      // negative angle: add one full circle
      if (hue_sum[AXW-1]) begin
         hue_sum = hue_sum + {1'b0, rgbhsl_pkg::FULL_CIRCLE};
      end
      hue_wrap_in = sd.gray ? '0 : hue_sum[AW-1:0];
      if (sd.gray) begin
         sat_in = '0;
      end else if (sd.sat_full) begin
         sat_in = rgbhsl_pkg::SAT_MAX;
      end else begin
         sat_in = sat_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hue_wrap_ff <= hue_wrap_in;
         sat_ff      <= sat_in;
         light_ff    <= sd.light;
      end
   end

   // ---------------- scale to 1/64 degree, output register ----------------
   logic [PW-1:0]         hue_prod;
   rgbhsl_pkg::hsl_type   out_ff;

   assign hue_prod = PW'(hue_wrap_ff) * PW'(rgbhsl_pkg::HUE_SCALE);

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.hue        <= hue_prod[PW-1:rgbhsl_pkg::HUE_SHIFT];
         out_ff.saturation <= sat_ff;
         out_ff.lightness  <= light_ff;
      end
   end

   assign rsp_if.valid = valid_ff[NSTG-1];
   assign rsp_if.data  = out_ff;

   // ---------------- assertions ----------------
   `RGBHSL_ASSERT_NEXT(a_stall_freezes, !adv,
      $stable(valid_ff) && $stable(hue_wrap_ff), "pipeline moved during a stall")
   `RGBHSL_ASSERT_NEXT(a_gray_zero, valid_ff[NDIV] && adv && side_ff[NDIV].gray,
      hue_wrap_ff == '0 && sat_ff == '0, "gray pixel gave nonzero hue or saturation")
   `RGBHSL_ASSERT_NEXT(a_hue_range, valid_ff[NSTG-2] && adv,
      rsp_if.data.hue < rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_CIRCLE),
      "hue beyond one full circle")

endmodule

// ----- sv/rgbhsl_div.sv -----
// Pipelined restoring divider: floor(num * 2^16 / den) for num < den.
module rgbhsl_div (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [rgbhsl_pkg::COMP_W-1:0]    num,
   input  logic [rgbhsl_pkg::DEN_W-1:0]     den,
   output logic [rgbhsl_pkg::QUO_W-1:0]     quo
);

   localparam int DW = rgbhsl_pkg::DEN_W;
   localparam int QW = rgbhsl_pkg::QUO_W;
   localparam int NS = rgbhsl_pkg::DIV_STAGES;

   logic [DW-1:0] rem_ff [NS-1];
   logic [DW-1:0] rem_in [NS-1];
   logic [DW-1:0] den_ff [NS-1];
   logic [DW-1:0] den_in [NS-1];
   logic [QW-1:0] quo_ff [NS];
   logic [QW-1:0] quo_in [NS];

   always_comb begin
      logic [DW-1:0] r;
      logic [DW-1:0] d;
      logic [DW:0]   r2;
      logic [QW-1:0] q;
      r  = '0;
      d  = '0;
      r2 = '0;
      q  = '0;
      for (int s = 0; s < NS; s++) begin
         if (s == 0) begin
            r = DW'(num);
            d = den;
            q = '0;
         end else begin
            r = rem_ff[s-1];
            d = den_ff[s-1];
            q = quo_ff[s-1];
         end
         // one quotient bit per step: double, compare, subtract
         for (int i = 0; i < rgbhsl_pkg::DIV_STEP; i++) begin
            r2 = {r, 1'b0};
            if (r2 >= {1'b0, d}) begin
               r2 = r2 - {1'b0, d};
               q  = {q[QW-2:0], 1'b1};
            end else begin
               q  = {q[QW-2:0], 1'b0};
            end
            r = r2[DW-1:0];
         end
         quo_in[s] = q;
         if (s < NS - 1) begin
            rem_in[s] = r;
            den_in[s] = d;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff[NS-1];

endmodule
